// ===== rtl/core/poly3_evaluator_macros.svh =====
// Assertion macros for the poly3_evaluator blocks.
// Used by p3e_back; no other dependencies.
`ifndef POLY3_EVALUATOR_MACROS_SVH
`define POLY3_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define P3E_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define P3E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define P3E_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define P3E_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/p3e_pkg.sv =====
// Shared types and codes for the poly3_evaluator.
// No dependencies.
`default_nettype none
package p3e_pkg;
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_EVAL   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] CFG_DEG_X = 2'd0;
    localparam logic [1:0] CFG_DEG_Y = 2'd1;
    localparam logic [1:0] CFG_DEG_Z = 2'd2;

    localparam logic signed [47:0] P48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] P48_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         exp_x;
        logic [2:0]         exp_y;
        logic [2:0]         exp_z;
        logic signed [31:0] coef_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] poly_value;
        logic               overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        K_WRITE,
        K_CLEAR,
        K_EVAL
    } t_cmd_kind;

    // request as queued between front and back
    typedef struct packed {
        t_cmd_kind          kind;
        logic [2:0]         exp_x;
        logic [2:0]         exp_y;
        logic [2:0]         exp_z;
        logic signed [31:0] coef_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_cmd;

    typedef struct packed {
        logic [2:0] deg_x;
        logic [2:0] deg_y;
        logic [2:0] deg_z;
    } t_deg;
endpackage
`default_nettype wire

// ===== rtl/core/p3e_mul.sv =====
// Sequential fixed-point multiplier: 48x48 signed via four 24x24 partial products,
// then shift by FRAC_BITS and saturate to 48 bits. Uses p3e_pkg.
`default_nettype none
module p3e_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [47:0] i_a,
    input  wire logic signed [47:0] i_b,
    output logic                    o_done,
    output logic signed [47:0]      o_prod,
    output logic                    o_sat
);
    import p3e_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_PP, M_NEG, M_SAT} t_mstate;

    t_mstate            r_state;
    logic [47:0]        r_ma, r_mb;
    logic               r_neg;
    logic [95:0]        r_acc;
    logic [1:0]         r_step;
    logic signed [96:0] r_sgn;
    logic               r_done, r_sat;
    logic signed [47:0] r_prod;

    logic [23:0]        w_ha, w_hb;
    logic [47:0]        w_pp;
    logic [95:0]        w_pps;
    logic signed [96:0] w_sh;
    logic               w_fits;

    // partial product of the selected halves
    always_comb begin
        w_ha = r_step[1] ? r_ma[47:24] : r_ma[23:0];
        w_hb = r_step[0] ? r_mb[47:24] : r_mb[23:0];
        w_pp = {24'd0, w_ha} * {24'd0, w_hb};
        case ({1'b0, r_step[1]} + {1'b0, r_step[0]})
            2'd0:    w_pps = {48'd0, w_pp};
            2'd1:    w_pps = {24'd0, w_pp, 24'd0};
            2'd2:    w_pps = {w_pp, 48'd0};
            default: w_pps = 96'd0;
        endcase
        w_sh   = r_sgn >>> FRAC_BITS;
        w_fits = (&w_sh[96:47]) || !(|w_sh[96:47]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_ma    <= i_a[47] ? 48'(-i_a) : i_a;
                        r_mb    <= i_b[47] ? 48'(-i_b) : i_b;
                        r_neg   <= i_a[47] ^ i_b[47];
                        r_acc   <= 96'd0;
                        r_step  <= 2'd0;
                        r_state <= M_PP;
                    end
                end
                M_PP: begin
                    r_acc  <= r_acc + w_pps;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= M_NEG;
                    end
                end
                M_NEG: begin
                    r_sgn   <= r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
                    r_state <= M_SAT;
                end
                M_SAT: begin
                    r_prod  <= w_fits ? w_sh[47:0] : (r_neg ? P48_MIN : P48_MAX);
                    r_sat   <= !w_fits;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
    assign o_sat  = r_sat;
endmodule
`default_nettype wire

// ===== rtl/core/p3e_front.sv =====
// Front end: degree registers, request classification and a two-entry queue.
// Uses p3e_pkg.
`default_nettype none
module p3e_front #(
    parameter int MAX_DEGREE = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire p3e_pkg::t_in_item i_item,
    input  wire logic              i_init,
    output logic                   o_busy,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [2:0]        i_cfg_data,
    output p3e_pkg::t_deg          o_deg,
    output p3e_pkg::t_cmd          o_cmd,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_pop
);
    import p3e_pkg::*;

    t_deg       r_deg;
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    logic       w_acc, w_keep, w_range_ok, w_push;
    t_cmd       w_cmd;

    // classify the incoming request
    always_comb begin
        w_acc      = i_start && !o_busy;
        w_range_ok = !(int'(i_item.exp_x) > int'(r_deg.deg_x) || int'(i_item.exp_x) > MAX_DEGREE ||
                       int'(i_item.exp_y) > int'(r_deg.deg_y) || int'(i_item.exp_y) > MAX_DEGREE ||
                       int'(i_item.exp_z) > int'(r_deg.deg_z) || int'(i_item.exp_z) > MAX_DEGREE);
        w_cmd.exp_x      = i_item.exp_x;
        w_cmd.exp_y      = i_item.exp_y;
        w_cmd.exp_z      = i_item.exp_z;
        w_cmd.coef_value = i_item.coef_value;
        w_cmd.point_x    = i_item.point_x;
        w_cmd.point_y    = i_item.point_y;
        w_cmd.point_z    = i_item.point_z;
        case (i_item.operation)
            OP_WRITE: begin
                w_cmd.kind = K_WRITE;
                w_keep     = w_range_ok;
            end
            OP_EVAL: begin
                w_cmd.kind = K_EVAL;
                w_keep     = 1'b1;
            end
            OP_CLEAR: begin
                w_cmd.kind = K_CLEAR;
                w_keep     = 1'b1;
            end
            default: begin
                w_cmd.kind = K_CLEAR;
                w_keep     = 1'b0;
            end
        endcase
        w_push = w_acc && w_keep;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // queue pointers and degree registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_deg <= '0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (i_cmd_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEG_X: r_deg.deg_x <= i_cfg_data;
                    CFG_DEG_Y: r_deg.deg_y <= i_cfg_data;
                    CFG_DEG_Z: r_deg.deg_z <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_busy      = (r_cnt == 2'd2) || i_init;
    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_deg       = r_deg;
endmodule
`default_nettype wire

// ===== rtl/core/p3e_back.sv =====
// Back end: coefficient memory, clearing sweep and the evaluation sequencer.
// Uses p3e_pkg, p3e_mul and poly3_evaluator_macros.svh.
`default_nettype none
`include "poly3_evaluator_macros.svh"
module p3e_back #(
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire p3e_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire p3e_pkg::t_deg i_deg,
    output logic               o_init,
    output logic               o_res_valid,
    output p3e_pkg::t_out_item o_result
);
    import p3e_pkg::*;

    localparam int DIM   = MAX_DEGREE + 1;
    localparam int DEPTH = DIM * DIM * DIM;
    localparam int CW    = $clog2(DIM);
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_RD, S_T0, S_M1, S_M2, S_M3, S_ADD, S_PZ, S_PY, S_PX
    } t_state;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] z);
        return AW'(x) + AW'(DIM) * (AW'(y) + AW'(DIM) * AW'(z));
    endfunction

    function automatic logic [CW-1:0] eff_deg(input logic [2:0] d);
        return (int'(d) > MAX_DEGREE) ? CW'(MAX_DEGREE) : CW'(d);
    endfunction

    localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    t_state             r_state;
    logic               r_init, r_mwait, r_valid, r_sat;
    logic [AW-1:0]      r_sweep;
    logic [CW-1:0]      r_cx, r_cy, r_cz;
    logic signed [47:0] r_ptx, r_pty, r_ptz, r_pwx, r_pwy, r_pwz, r_term;
    logic signed [63:0] r_acc;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;
    logic [CW-1:0]      w_dx, w_dy, w_dz;
    logic               w_mstart, w_mdone, w_msat;
    logic signed [47:0] w_ma, w_mb, w_mprod;
    logic signed [63:0] w_t64, w_sum;
    logic               w_ovf;
    logic               w_pop;

    assign w_dx = eff_deg(i_deg.deg_x);
    assign w_dy = eff_deg(i_deg.deg_y);
    assign w_dz = eff_deg(i_deg.deg_z);

    // memory write selection
    always_comb begin
        w_pop   = (r_state == S_IDLE) && i_cmd_valid;
        w_we    = 1'b0;
        w_waddr = r_sweep;
        w_wdata = 32'sd0;
        if (r_state == S_SWEEP) begin
            w_we = 1'b1;
        end else if (w_pop && i_cmd.kind == K_WRITE) begin
            w_we    = 1'b1;
            w_waddr = addr_of(CW'(i_cmd.exp_x), CW'(i_cmd.exp_y), CW'(i_cmd.exp_z));
            w_wdata = i_cmd.coef_value;
        end
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[addr_of(r_cx, r_cy, r_cz)];
    end

    // multiplier operand selection
    always_comb begin
        w_ma = r_term;
        w_mb = r_pwx;
        case (r_state)
            S_M2: w_mb = r_pwy;
            S_M3: w_mb = r_pwz;
            S_PZ: begin
                w_ma = r_pwz;
                w_mb = r_ptz;
            end
            S_PY: begin
                w_ma = r_pwy;
                w_mb = r_pty;
            end
            S_PX: begin
                w_ma = r_pwx;
                w_mb = r_ptx;
            end
            default: ;
        endcase
        w_mstart = !r_mwait && (r_state == S_M1 || r_state == S_M2 || r_state == S_M3 ||
                                r_state == S_PZ || r_state == S_PY || r_state == S_PX);
    end

    p3e_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_mprod),
        .o_sat   (w_msat)
    );

    // saturating accumulate
    always_comb begin
        w_t64 = {{16{r_term[47]}}, r_term};
        w_sum = r_acc + w_t64;
        w_ovf = (r_acc[63] == w_t64[63]) && (w_sum[63] != r_acc[63]);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_init  <= 1'b1;
            r_sweep <= '0;
            r_mwait <= 1'b0;
            r_valid <= 1'b0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
        end else begin
            r_valid <= 1'b0;
            if (w_mstart) r_mwait <= 1'b1;
            if (w_mdone) begin
                r_mwait <= 1'b0;
                r_sat   <= r_sat | w_msat;
            end
            case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + AW'(1);
                    if (r_sweep == AW'(DEPTH - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_pop) begin
                        case (i_cmd.kind)
                            K_CLEAR: begin
                                r_sweep <= '0;
                                r_state <= S_SWEEP;
                            end
                            K_EVAL: begin
                                r_ptx   <= 48'(i_cmd.point_x);
                                r_pty   <= 48'(i_cmd.point_y);
                                r_ptz   <= 48'(i_cmd.point_z);
                                r_pwx   <= ONE;
                                r_pwy   <= ONE;
                                r_pwz   <= ONE;
                                r_cx    <= '0;
                                r_cy    <= '0;
                                r_cz    <= '0;
                                r_acc   <= 64'sd0;
                                r_sat   <= 1'b0;
                                r_state <= S_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: r_state <= S_T0;
                S_T0: begin
                    r_term  <= 48'(r_rdata);
                    r_state <= S_M1;
                end
                S_M1: if (w_mdone) begin
                    r_term  <= w_mprod;
                    r_state <= S_M2;
                end
                S_M2: if (w_mdone) begin
                    r_term  <= w_mprod;
                    r_state <= S_M3;
                end
                S_M3: if (w_mdone) begin
                    r_term  <= w_mprod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= w_ovf ? (r_acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : w_sum;
                    if (w_ovf) r_sat <= 1'b1;
                    if (r_cz < w_dz) begin
                        r_cz    <= r_cz + CW'(1);
                        r_state <= S_PZ;
                    end else begin
                        r_cz  <= '0;
                        r_pwz <= ONE;
                        if (r_cy < w_dy) begin
                            r_cy    <= r_cy + CW'(1);
                            r_state <= S_PY;
                        end else begin
                            r_cy  <= '0;
                            r_pwy <= ONE;
                            if (r_cx < w_dx) begin
                                r_cx    <= r_cx + CW'(1);
                                r_state <= S_PX;
                            end else begin
                                r_cx    <= '0;
                                r_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_PZ: if (w_mdone) begin
                    r_pwz   <= w_mprod;
                    r_state <= S_RD;
                end
                S_PY: if (w_mdone) begin
                    r_pwy   <= w_mprod;
                    r_state <= S_RD;
                end
                S_PX: if (w_mdone) begin
                    r_pwx   <= w_mprod;
                    r_state <= S_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd_pop            = w_pop;
    assign o_init               = r_init;
    assign o_res_valid          = r_valid;
    assign o_result.poly_value  = r_acc;
    assign o_result.overflow    = r_sat;

    // result strobe lasts one cycle
    `P3E_ASSERT_NEXT(a_res_pulse, i_clk, i_rst_n, r_valid, !r_valid)
    // multiplier answers only an outstanding request
    `P3E_ASSERT_NOW(a_mul_owned, i_clk, i_rst_n, w_mdone, r_mwait)
    // no request is taken during the reset sweep
    `P3E_ASSERT_NOW(a_init_hold, i_clk, i_rst_n, r_init, !w_pop)
endmodule
`default_nettype wire

// ===== rtl/core/poly3_evaluator.sv =====
// Evaluation walks (dx+1)(dy+1)(dz+1) terms; each term takes a memory read,
// three products and an add, and all but the last one power update; products
// and power updates share the one multiplier. A clear writes zero to all DIM^3
// (512) coefficient entries. A two-entry queue takes requests while the back
// works. After reset a clearing sweep runs with busy high; results are
// one-cycle strobes the receiver cannot stall.
`default_nettype none
module poly3_evaluator #(
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire p3e_pkg::t_in_item i_item,
    output logic                   o_valid,
    output p3e_pkg::t_out_item     o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [2:0]        i_cfg_data
);
    import p3e_pkg::*;

    t_cmd w_cmd;
    t_deg w_deg;
    logic w_cmd_valid, w_cmd_pop, w_init;

    p3e_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .i_init      (w_init),
        .o_busy      (o_busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_deg       (w_deg),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    p3e_back #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_deg       (w_deg),
        .o_init      (w_init),
        .o_res_valid (o_valid),
        .o_result    (o_result)
    );
endmodule
`default_nettype wire
